FILE: design/graham_scan_convex_hull_defines.svh
// ----------------------------------------------------------------------------
// Convex hull assertion macros
// Wrappers for concurrent checks with |-> and |=> implication, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef GRAHAM_SCAN_CONVEX_HULL_DEFINES_SVH
`define GRAHAM_SCAN_CONVEX_HULL_DEFINES_SVH

`ifndef SYNTHESIS
`define GSCH_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("gsch check failed");
`define GSCH_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("gsch check failed");
`else
`define GSCH_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define GSCH_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

FILE: design/gsch_pkg.sv
// ----------------------------------------------------------------------------
// Convex hull package
// Shared defaults, state encoding and controller/datapath interface types.
// ----------------------------------------------------------------------------
package gsch_pkg;

    localparam int MAX_POINTS_DEF  = 64;
    localparam int COORD_WIDTH_DEF = 16;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_SW0,
        ST_SW1,
        ST_SO_LT,
        ST_SO_GT,
        ST_SO_RD,
        ST_SO_MUL,
        ST_SO_DEC,
        ST_SO_PUT,
        ST_TH_RD,
        ST_TH_MUL,
        ST_TH_DEC,
        ST_SI_RD,
        ST_SI_WR,
        ST_SC_RD,
        ST_SC_MUL,
        ST_SC_DEC,
        ST_OUT_RD,
        ST_OUT_LD,
        ST_OUT_WAIT,
        ST_DEG
    } t_state;

    typedef enum logic [2:0] {
        WS_IN,
        WS_FIRST,
        WS_PIVOT,
        WS_T,
        WS_RDA
    } t_wsel;

    typedef enum logic [1:0] {
        GS_SORT,
        GS_THIN,
        GS_SCAN
    } t_gsel;

    typedef struct packed {
        logic  mem_we;
        t_wsel wsel;
        logic  pt_load;
        logic  pt_first;
        logic  t_load;
        logic  stk_we;
        t_gsel gsel;
        logic  out_load;
        logic  out_zero;
        logic  out_last;
    } t_cmd;

    typedef struct packed {
        logic col;
        logic ccw;
        logic ahead;
    } t_status;

endpackage

FILE: design/graham_scan_convex_hull.sv
// ----------------------------------------------------------------------------
// Graham scan convex hull
// Collects a point set, then emits its convex hull vertices.
// ----------------------------------------------------------------------------
// Input channel: one point word per cycle (i_in_x, i_in_y, i_last_point) with
// i_valid/o_stall. Up to MAX_POINTS points are stored; extra points are
// dropped. The word with i_last_point set closes the set and starts the hull.
// While the hull is computed and emitted o_stall stays high.
// Output channel: o_valid/i_stall. Vertices come from stack top down to the
// pivot; the pivot carries o_last_result. With fewer than three usable points
// one word with o_no_hull set and zero coordinates is sent.
// Phases for n points: load; pivot swap; insertion sort (about n*n/2
// compares worst case); thinning; stack start; stack scan; then one result
// word per hull vertex.
// A stalled result word holds until taken. Reset returns to loading with an
// empty store; no clearing pass is needed.
// ----------------------------------------------------------------------------
module graham_scan_convex_hull
    import gsch_pkg::*;
#(
    parameter int MAX_POINTS  = MAX_POINTS_DEF,
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [COORD_WIDTH-1:0] i_in_x,
    input  logic signed [COORD_WIDTH-1:0] i_in_y,
    input  logic                          i_last_point,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [COORD_WIDTH-1:0] o_out_x,
    output logic signed [COORD_WIDTH-1:0] o_out_y,
    output logic                          o_no_hull,
    output logic                          o_last_result
);

`include "graham_scan_convex_hull_defines.svh"

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

    t_cmd          cmd;
    t_status       status;
    logic [AW-1:0] addr_w, addr_a, addr_b, stk_addr_w, stk_addr_0, stk_addr_1;
    logic [AW-1:0] best_idx;

    gsch_ctrl #(
        .MAX_POINTS (MAX_POINTS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_last_point (i_last_point),
        .o_stall      (o_stall),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .i_best_idx   (best_idx),
        .i_status     (status),
        .o_cmd        (cmd),
        .o_addr_w     (addr_w),
        .o_addr_a     (addr_a),
        .o_addr_b     (addr_b),
        .o_stk_addr_w (stk_addr_w),
        .o_stk_addr_0 (stk_addr_0),
        .o_stk_addr_1 (stk_addr_1)
    );

    gsch_datapath #(
        .MAX_POINTS  (MAX_POINTS),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_cmd         (cmd),
        .i_addr_w      (addr_w),
        .i_addr_a      (addr_a),
        .i_addr_b      (addr_b),
        .i_stk_addr_w  (stk_addr_w),
        .i_stk_addr_0  (stk_addr_0),
        .i_stk_addr_1  (stk_addr_1),
        .i_in_x        (i_in_x),
        .i_in_y        (i_in_y),
        .o_best_idx    (best_idx),
        .o_status      (status),
        .o_out_x       (o_out_x),
        .o_out_y       (o_out_y),
        .o_no_hull     (o_no_hull),
        .o_last_result (o_last_result)
    );

    `GSCH_ASSERT_IMP(a_no_hull_word, i_clk, i_rst_n, o_valid && o_no_hull, o_last_result && (o_out_x == '0) && (o_out_y == '0))
    `GSCH_ASSERT_NXT(a_last_starts_hull, i_clk, i_rst_n, i_valid && !o_stall && i_last_point, o_stall)
    `GSCH_ASSERT_IMP(a_no_load_while_out, i_clk, i_rst_n, o_valid, o_stall)
    `GSCH_ASSERT_IMP(a_out_needs_set, i_clk, i_rst_n, cmd.out_load, !o_valid)

endmodule

FILE: design/gsch_datapath.sv
// ----------------------------------------------------------------------------
// Convex hull datapath
// Point store, hull stack, pivot tracking, orientation unit, result register.
// ----------------------------------------------------------------------------
module gsch_datapath
    import gsch_pkg::*;
#(
    parameter int MAX_POINTS  = MAX_POINTS_DEF,
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1
) (
    input  logic                          i_clk,
    input  t_cmd                          i_cmd,
    input  logic [AW-1:0]                 i_addr_w,
    input  logic [AW-1:0]                 i_addr_a,
    input  logic [AW-1:0]                 i_addr_b,
    input  logic [AW-1:0]                 i_stk_addr_w,
    input  logic [AW-1:0]                 i_stk_addr_0,
    input  logic [AW-1:0]                 i_stk_addr_1,
    input  logic signed [COORD_WIDTH-1:0] i_in_x,
    input  logic signed [COORD_WIDTH-1:0] i_in_y,
    output logic [AW-1:0]                 o_best_idx,
    output t_status                       o_status,
    output logic signed [COORD_WIDTH-1:0] o_out_x,
    output logic signed [COORD_WIDTH-1:0] o_out_y,
    output logic                          o_no_hull,
    output logic                          o_last_result
);

    localparam int CW = COORD_WIDTH;
    localparam int PW = 2 * CW;
    localparam int MW = 2 * CW + 2;

    logic [PW-1:0] r_mem [MAX_POINTS];
    logic [PW-1:0] r_stk [MAX_POINTS];
    logic [PW-1:0] r_rda, r_rdb, r_sd0, r_sd1;
    logic [PW-1:0] r_first, r_best, r_t;
    logic [AW-1:0] r_best_idx;
    logic [PW-1:0] in_pt, wdata, op_p, op_q, op_r;
    logic          better;

    logic signed [CW-1:0] px, py, qx, qy, rx, ry;
    logic signed [CW:0]   d_qy_py, d_rx_qx, d_qx_px, d_ry_qy, d_rx_px, d_ry_py;
    logic [CW:0]          adx_q, adx_r;
    logic                 near;

    logic signed [MW-1:0] r_ma, r_mb;
    logic                 r_za, r_zb, r_near;

    logic signed [CW-1:0] r_out_x, r_out_y;
    logic                 r_no_hull, r_last;

    assign in_pt  = {i_in_y, i_in_x};
    assign better = ($signed(i_in_y) < $signed(r_best[PW-1:CW])) ||
                    (($signed(i_in_y) == $signed(r_best[PW-1:CW])) &&
                     ($signed(i_in_x) < $signed(r_best[CW-1:0])));

    always_comb begin
        unique case (i_cmd.wsel)
            WS_IN:    wdata = in_pt;
            WS_FIRST: wdata = r_first;
            WS_PIVOT: wdata = r_best;
            WS_T:     wdata = r_t;
            WS_RDA:   wdata = r_rda;
            default:  wdata = r_rda;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_we) begin
            r_mem[i_addr_w] <= wdata;
        end
        r_rda <= r_mem[i_addr_a];
        r_rdb <= r_mem[i_addr_b];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.stk_we) begin
            r_stk[i_stk_addr_w] <= r_rda;
        end
        r_sd0 <= r_stk[i_stk_addr_0];
        r_sd1 <= r_stk[i_stk_addr_1];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pt_load) begin
            if (i_cmd.pt_first || better) begin
                r_best     <= in_pt;
                r_best_idx <= i_addr_w;
            end
            if (i_cmd.pt_first) begin
                r_first <= in_pt;
            end
        end
        if (i_cmd.t_load) begin
            r_t <= r_rda;
        end
    end

    assign o_best_idx = r_best_idx;

    // orientation operands
    always_comb begin
        unique case (i_cmd.gsel)
            GS_SORT: begin
                op_p = r_best;
                op_q = r_t;
                op_r = r_rda;
            end
            GS_THIN: begin
                op_p = r_best;
                op_q = r_rda;
                op_r = r_rdb;
            end
            GS_SCAN: begin
                op_p = r_sd0;
                op_q = r_sd1;
                op_r = r_rda;
            end
            default: begin
                op_p = r_best;
                op_q = r_t;
                op_r = r_rda;
            end
        endcase
    end

    assign px = op_p[CW-1:0];
    assign py = op_p[PW-1:CW];
    assign qx = op_q[CW-1:0];
    assign qy = op_q[PW-1:CW];
    assign rx = op_r[CW-1:0];
    assign ry = op_r[PW-1:CW];

    assign d_qy_py = (CW+1)'(qy) - (CW+1)'(py);
    assign d_rx_qx = (CW+1)'(rx) - (CW+1)'(qx);
    assign d_qx_px = (CW+1)'(qx) - (CW+1)'(px);
    assign d_ry_qy = (CW+1)'(ry) - (CW+1)'(qy);
    assign d_rx_px = (CW+1)'(rx) - (CW+1)'(px);
    assign d_ry_py = (CW+1)'(ry) - (CW+1)'(py);

    // both points lie on one ray above the pivot, so compare |dx| then dy
    assign adx_q = d_qx_px[CW] ? (CW+1)'(-d_qx_px) : d_qx_px;
    assign adx_r = d_rx_px[CW] ? (CW+1)'(-d_rx_px) : d_rx_px;
    assign near  = (adx_q < adx_r) || ((adx_q == adx_r) && (d_qy_py < d_ry_py));

    always_ff @(posedge i_clk) begin
        r_ma   <= MW'(d_qy_py) * MW'(d_rx_qx);
        r_mb   <= MW'(d_qx_px) * MW'(d_ry_qy);
        r_za   <= (op_q == op_p);
        r_zb   <= (op_r == op_p);
        r_near <= near;
    end

    always_comb begin
        o_status.col   = (r_ma == r_mb);
        o_status.ccw   = (r_ma < r_mb);
        o_status.ahead = !r_zb && (r_za || (r_ma < r_mb) || ((r_ma == r_mb) && r_near));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (i_cmd.out_zero) begin
                r_out_x   <= '0;
                r_out_y   <= '0;
                r_no_hull <= 1'b1;
                r_last    <= 1'b1;
            end else begin
                r_out_x   <= r_sd0[CW-1:0];
                r_out_y   <= r_sd0[PW-1:CW];
                r_no_hull <= 1'b0;
                r_last    <= i_cmd.out_last;
            end
        end
    end

    assign o_out_x       = r_out_x;
    assign o_out_y       = r_out_y;
    assign o_no_hull     = r_no_hull;
    assign o_last_result = r_last;

endmodule

FILE: design/gsch_ctrl.sv
// ----------------------------------------------------------------------------
// Convex hull controller
// Sequences load, pivot swap, insertion sort, thinning, stack scan, output.
// ----------------------------------------------------------------------------
module gsch_ctrl
    import gsch_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    localparam int AW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
    localparam int CNW = $clog2(MAX_POINTS + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_last_point,
    output logic          o_stall,
    output logic          o_valid,
    input  logic          i_stall,
    input  logic [AW-1:0] i_best_idx,
    input  t_status       i_status,
    output t_cmd          o_cmd,
    output logic [AW-1:0] o_addr_w,
    output logic [AW-1:0] o_addr_a,
    output logic [AW-1:0] o_addr_b,
    output logic [AW-1:0] o_stk_addr_w,
    output logic [AW-1:0] o_stk_addr_0,
    output logic [AW-1:0] o_stk_addr_1
);

    t_state         r_state, n_state;
    logic [CNW-1:0] r_n, n_n, r_i, n_i, r_j, n_j, r_m, n_m, r_sp, n_sp;
    logic           r_valid, n_valid;
    logic [CNW-1:0] i_inc, j_dec, m_inc, sp_dec, sp_dec2;

    assign i_inc   = r_i + CNW'(1);
    assign j_dec   = r_j - CNW'(1);
    assign m_inc   = r_m + CNW'(1);
    assign sp_dec  = r_sp - CNW'(1);
    assign sp_dec2 = r_sp - CNW'(2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_n     <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_m     <= '0;
            r_sp    <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_n     <= n_n;
            r_i     <= n_i;
            r_j     <= n_j;
            r_m     <= n_m;
            r_sp    <= n_sp;
            r_valid <= n_valid;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_n          = r_n;
        n_i          = r_i;
        n_j          = r_j;
        n_m          = r_m;
        n_sp         = r_sp;
        n_valid      = r_valid;
        o_cmd        = '0;
        o_addr_w     = r_n[AW-1:0];
        o_addr_a     = r_i[AW-1:0];
        o_addr_b     = i_inc[AW-1:0];
        o_stk_addr_w = r_sp[AW-1:0];
        o_stk_addr_0 = sp_dec2[AW-1:0];
        o_stk_addr_1 = sp_dec[AW-1:0];
        o_stall      = (r_state != ST_LOAD);

        unique case (r_state)
            ST_LOAD: begin
                if (i_valid) begin
                    if (r_n < CNW'(MAX_POINTS)) begin
                        o_cmd.mem_we   = 1'b1;
                        o_cmd.wsel     = WS_IN;
                        o_cmd.pt_load  = 1'b1;
                        o_cmd.pt_first = (r_n == '0);
                        n_n            = r_n + CNW'(1);
                    end
                    if (i_last_point) begin
                        n_state = ST_SW0;
                    end
                end
            end
            ST_SW0: begin
                o_cmd.mem_we = 1'b1;
                o_cmd.wsel   = WS_FIRST;
                o_addr_w     = i_best_idx;
                n_state      = ST_SW1;
            end
            ST_SW1: begin
                o_cmd.mem_we = 1'b1;
                o_cmd.wsel   = WS_PIVOT;
                o_addr_w     = '0;
                n_i          = CNW'(2);
                n_m          = CNW'(1);
                if (r_n > CNW'(2)) begin
                    n_state = ST_SO_LT;
                end else if (r_n == CNW'(2)) begin
                    n_i     = CNW'(1);
                    n_state = ST_TH_RD;
                end else begin
                    n_state = ST_DEG;
                end
            end
            ST_SO_LT: begin
                n_state = ST_SO_GT;
            end
            ST_SO_GT: begin
                o_cmd.t_load = 1'b1;
                n_j          = r_i;
                n_state      = ST_SO_RD;
            end
            ST_SO_RD: begin
                o_addr_a = j_dec[AW-1:0];
                n_state  = ST_SO_MUL;
            end
            ST_SO_MUL: begin
                o_addr_a   = j_dec[AW-1:0];
                o_cmd.gsel = GS_SORT;
                n_state    = ST_SO_DEC;
            end
            ST_SO_DEC: begin
                o_addr_a   = j_dec[AW-1:0];
                o_cmd.gsel = GS_SORT;
                if (i_status.ahead) begin
                    o_cmd.mem_we = 1'b1;
                    o_cmd.wsel   = WS_RDA;
                    o_addr_w     = r_j[AW-1:0];
                    n_j          = j_dec;
                    n_state      = (j_dec > CNW'(1)) ? ST_SO_RD : ST_SO_PUT;
                end else begin
                    n_state = ST_SO_PUT;
                end
            end
            ST_SO_PUT: begin
                o_cmd.mem_we = 1'b1;
                o_cmd.wsel   = WS_T;
                o_addr_w     = r_j[AW-1:0];
                if (i_inc < r_n) begin
                    n_i     = i_inc;
                    n_state = ST_SO_LT;
                end else begin
                    n_i     = CNW'(1);
                    n_m     = CNW'(1);
                    n_state = ST_TH_RD;
                end
            end
            ST_TH_RD: begin
                o_cmd.gsel = GS_THIN;
                n_state    = ST_TH_MUL;
            end
            ST_TH_MUL: begin
                o_cmd.gsel = GS_THIN;
                n_state    = ST_TH_DEC;
            end
            ST_TH_DEC: begin
                o_cmd.gsel = GS_THIN;
                n_i        = i_inc;
                if ((i_inc < r_n) && i_status.col) begin
                    n_state = ST_TH_RD;
                end else begin
                    o_cmd.mem_we = 1'b1;
                    o_cmd.wsel   = WS_RDA;
                    o_addr_w     = r_m[AW-1:0];
                    n_m          = m_inc;
                    if (i_inc < r_n) begin
                        n_state = ST_TH_RD;
                    end else if (m_inc < CNW'(3)) begin
                        n_state = ST_DEG;
                    end else begin
                        n_i     = '0;
                        n_sp    = '0;
                        n_state = ST_SI_RD;
                    end
                end
            end
            ST_SI_RD: begin
                n_state = ST_SI_WR;
            end
            ST_SI_WR: begin
                o_cmd.stk_we = 1'b1;
                n_sp         = r_sp + CNW'(1);
                n_i          = i_inc;
                if (r_i < CNW'(2)) begin
                    n_state = ST_SI_RD;
                end else if (r_m > CNW'(3)) begin
                    n_state = ST_SC_RD;
                end else begin
                    n_state = ST_OUT_RD;
                end
            end
            ST_SC_RD: begin
                o_cmd.gsel = GS_SCAN;
                n_state    = ST_SC_MUL;
            end
            ST_SC_MUL: begin
                o_cmd.gsel = GS_SCAN;
                n_state    = ST_SC_DEC;
            end
            ST_SC_DEC: begin
                o_cmd.gsel = GS_SCAN;
                if ((r_sp > CNW'(1)) && !i_status.ccw) begin
                    n_sp    = sp_dec;
                    n_state = ST_SC_RD;
                end else begin
                    o_cmd.stk_we = 1'b1;
                    n_sp         = r_sp + CNW'(1);
                    n_i          = i_inc;
                    n_state      = (i_inc < r_m) ? ST_SC_RD : ST_OUT_RD;
                end
            end
            ST_OUT_RD: begin
                o_stk_addr_0 = sp_dec[AW-1:0];
                n_state      = ST_OUT_LD;
            end
            ST_OUT_LD: begin
                o_stk_addr_0   = sp_dec[AW-1:0];
                o_cmd.out_load = 1'b1;
                o_cmd.out_last = (r_sp == CNW'(1));
                n_sp           = sp_dec;
                n_valid        = 1'b1;
                n_state        = ST_OUT_WAIT;
            end
            ST_OUT_WAIT: begin
                if (!i_stall) begin
                    n_valid = 1'b0;
                    if (r_sp == '0) begin
                        n_n     = '0;
                        n_state = ST_LOAD;
                    end else begin
                        n_state = ST_OUT_RD;
                    end
                end
            end
            ST_DEG: begin
                o_cmd.out_load = 1'b1;
                o_cmd.out_zero = 1'b1;
                n_sp           = '0;
                n_valid        = 1'b1;
                n_state        = ST_OUT_WAIT;
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    assign o_valid = r_valid;

endmodule
